FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the tokenizer RTL. Empty under synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold on every clock edge outside reset
`define SWT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tokenizer assertion failed");

// condition must never be seen outside reset
`define SWT_NEVER(lbl, clk, rst, cond) \
   `SWT_ASSERT(lbl, clk, rst, !(cond))

`else

`define SWT_ASSERT(lbl, clk, rst, prop)
`define SWT_NEVER(lbl, clk, rst, cond)

`endif

`endif

FILE: rtl/core/swt_pkg.sv
// ---------------------------------------------------------------------------
// swt_pkg
// Types and character constants for the shell word tokenizer.
// ---------------------------------------------------------------------------
`default_nettype none

package swt_pkg;

   // quoting mode of the parser
   typedef enum logic [1:0] {
      MODE_PLAIN  = 2'd0,
      MODE_SINGLE = 2'd1,
      MODE_DOUBLE = 2'd2
   } mode_type;

   // kind of one result beat
   typedef enum logic [1:0] {
      KIND_BYTE     = 2'd0,
      KIND_WORD_END = 2'd1,
      KIND_LINE_END = 2'd2
   } kind_type;

   // special characters
   localparam logic [7:0] CH_PIPE   = 8'h7C;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_BTICK  = 8'h60;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   // at most three results per input byte
   localparam int RES_MAX = 3;

   // bundle queue between front and back (power of two, pointers wrap)
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      kind_type   kind;
      logic [7:0] ch;
   } result_type;

   // all results caused by one input byte; cnt is 1..3
   typedef struct packed {
      logic [1:0]                   cnt;
      result_type [RES_MAX-1:0]     res;
   } bundle_type;

endpackage

`default_nettype wire

FILE: rtl/core/swt_front.sv
// ---------------------------------------------------------------------------
// swt_front
// Classifies each accepted byte against the quoting state and builds the
// bundle of results it causes. Holds the parser state.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module swt_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_fire,
   input  wire                  in_action,
   input  wire [7:0]            in_char,
   output logic                 push,
   output swt_pkg::bundle_type  push_bundle
);
   import swt_pkg::*;

   mode_type   mode_ff, mode_in;
   logic       esc_ff, esc_in;
   logic       open_ff, open_in;

   logic [1:0] cnt;
   bundle_type bnd;
   logic       is_blank;
   logic       is_dq_escape;

   assign is_blank     = (in_char == CH_SPACE) || (in_char inside {[CH_TAB:CH_CR]});
   assign is_dq_escape = in_char inside {CH_DQUOTE, CH_BSLASH, CH_DOLLAR, CH_BTICK};

   // result generation and next parser state
   always_comb begin
      cnt     = 2'd0;
      bnd     = '0;
      mode_in = mode_ff;
      esc_in  = esc_ff;
      open_in = open_ff;
      if (in_action) begin
         // end of line: flush held backslash, close word, mark line end
         if (esc_ff) begin
            bnd.res[cnt] = '{kind: KIND_BYTE, ch: CH_BSLASH};
            cnt = cnt + 2'd1;
         end
         if (open_ff || esc_ff) begin
            bnd.res[cnt] = '{kind: KIND_WORD_END, ch: 8'h00};
            cnt = cnt + 2'd1;
         end
         bnd.res[cnt] = '{kind: KIND_LINE_END, ch: 8'h00};
         cnt = cnt + 2'd1;
         mode_in = MODE_PLAIN;
         esc_in  = 1'b0;
         open_in = 1'b0;
      end else begin
         case (mode_ff)
            MODE_SINGLE: begin
               open_in = 1'b1;
               if (in_char == CH_SQUOTE) begin
                  mode_in = MODE_PLAIN;
               end else begin
                  bnd.res[cnt] = '{kind: KIND_BYTE, ch: in_char};
                  cnt = cnt + 2'd1;
               end
            end
            MODE_DOUBLE: begin
               open_in = 1'b1;
               if (esc_ff && is_dq_escape) begin
                  esc_in = 1'b0;
                  bnd.res[cnt] = '{kind: KIND_BYTE, ch: in_char};
                  cnt = cnt + 2'd1;
               end else begin
                  // backslash before an ordinary byte is kept
                  if (esc_ff) begin
                     esc_in = 1'b0;
                     bnd.res[cnt] = '{kind: KIND_BYTE, ch: CH_BSLASH};
                     cnt = cnt + 2'd1;
                  end
                  if (in_char == CH_DQUOTE) begin
                     mode_in = MODE_PLAIN;
                  end else if (in_char == CH_BSLASH) begin
                     esc_in = 1'b1;
                  end else begin
                     bnd.res[cnt] = '{kind: KIND_BYTE, ch: in_char};
                     cnt = cnt + 2'd1;
                  end
               end
            end
            default: begin
               // outside quotes
               if (esc_ff) begin
                  esc_in  = 1'b0;
                  open_in = 1'b1;
                  bnd.res[cnt] = '{kind: KIND_BYTE, ch: in_char};
                  cnt = cnt + 2'd1;
               end else if (in_char == CH_PIPE) begin
                  if (open_ff) begin
                     bnd.res[cnt] = '{kind: KIND_WORD_END, ch: 8'h00};
                     cnt = cnt + 2'd1;
                  end
                  bnd.res[cnt] = '{kind: KIND_BYTE, ch: CH_PIPE};
                  cnt = cnt + 2'd1;
                  bnd.res[cnt] = '{kind: KIND_WORD_END, ch: 8'h00};
                  cnt = cnt + 2'd1;
                  open_in = 1'b0;
               end else if (is_blank) begin
                  if (open_ff) begin
                     bnd.res[cnt] = '{kind: KIND_WORD_END, ch: 8'h00};
                     cnt = cnt + 2'd1;
                  end
                  open_in = 1'b0;
               end else if (in_char == CH_SQUOTE) begin
                  mode_in = MODE_SINGLE;
                  open_in = 1'b1;
               end else if (in_char == CH_DQUOTE) begin
                  mode_in = MODE_DOUBLE;
                  open_in = 1'b1;
               end else if (in_char == CH_BSLASH) begin
                  esc_in = 1'b1;
               end else begin
                  open_in = 1'b1;
                  bnd.res[cnt] = '{kind: KIND_BYTE, ch: in_char};
                  cnt = cnt + 2'd1;
               end
            end
         endcase
      end
      bnd.cnt = cnt;
   end

   // only bytes that produce results take a queue slot
   assign push        = in_fire && (cnt != 2'd0);
   assign push_bundle = bnd;

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         esc_ff  <= 1'b0;
         open_ff <= 1'b0;
      end else if (in_fire) begin
         mode_ff <= mode_in;
         esc_ff  <= esc_in;
         open_ff <= open_in;
      end
   end

   // line end returns the parser to its reset state
   `SWT_ASSERT(a_line_end_clears, clock, reset,
      (in_fire && in_action) |=> (mode_ff == MODE_PLAIN && !esc_ff && !open_ff))
   // no escape is ever held inside single quotes
   `SWT_NEVER(a_no_esc_in_single, clock, reset, esc_ff && (mode_ff == MODE_SINGLE))

endmodule

`default_nettype wire

FILE: rtl/core/swt_queue.sv
// ---------------------------------------------------------------------------
// swt_queue
// Short FIFO of result bundles between the classifier and the serializer.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module swt_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  swt_pkg::bundle_type  push_bundle,
   input  wire                  pop,
   output logic                 full,
   output logic                 empty,
   output swt_pkg::bundle_type  head
);
   import swt_pkg::*;

   bundle_type            mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_bundle;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   `SWT_NEVER(a_no_overflow, clock, reset, push && full)
   `SWT_ASSERT(a_level_matches_ptrs, clock, reset,
      (wr_ptr_ff - rd_ptr_ff) == count_ff[QUEUE_AW-1:0])

endmodule

`default_nettype wire

FILE: rtl/core/swt_back.sv
// ---------------------------------------------------------------------------
// swt_back
// Serializes the head bundle onto the result stream, one beat per result,
// and flags the final beat of each bundle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module swt_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  head_valid,
   input  swt_pkg::bundle_type  head,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic [1:0]           rsp_tuser,
   output logic                 rsp_tlast
);
   import swt_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       last;
   logic       beat;
   result_type cur;

   assign cur        = head.res[idx_ff];
   assign last       = (idx_ff == (head.cnt - 2'd1));
   assign rsp_tvalid = head_valid;
   assign rsp_tdata  = cur.ch;
   assign rsp_tuser  = cur.kind;
   assign rsp_tlast  = last;
   assign beat       = rsp_tvalid && rsp_tready;
   assign pop        = beat && last;

   always_comb begin
      idx_in = idx_ff;
      if (beat) begin
         idx_in = last ? 2'd0 : (idx_ff + 2'd1);
      end
   end

   // position inside the head bundle
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   `SWT_ASSERT(a_idx_in_bundle, clock, reset,
      head_valid |-> ((head.cnt != 2'd0) && (idx_ff < head.cnt)))

endmodule

`default_nettype wire

FILE: rtl/core/shell_word_tokenizer.sv
// Path: accepted bytes' results are queued, then sent on rsp from the head.
// Throughput: one byte per cycle in while the queue is not full; results
// leave one beat per cycle while rsp_tready is high, one beat per result.
// A 4-bundle queue between classifier and serializer absorbs output stalls.
// Reset: synchronous, active high; clears parser state and the queue.
// ---------------------------------------------------------------------------
// shell_word_tokenizer
// Splits a byte stream into shell-style words with quote and escape handling.
// ---------------------------------------------------------------------------
`default_nettype none

module shell_word_tokenizer (
   input  wire        clock,
   input  wire        reset,
   // request stream
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [7:0] char_value
   input  wire        req_tuser,   // [0] action
   // result stream
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [1:0] rsp_tuser,   // [1:0] out_kind
   output logic       rsp_tlast    // last_of_run
);
   import swt_pkg::*;

   logic       in_fire;
   logic       push;
   logic       pop;
   logic       q_full;
   logic       q_empty;
   bundle_type push_bundle;
   bundle_type head;

   assign req_tready = !q_full;
   assign in_fire    = req_tvalid && req_tready;

   swt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_fire     (in_fire),
      .in_action   (req_tuser),
      .in_char     (req_tdata),
      .push        (push),
      .push_bundle (push_bundle)
   );

   swt_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .full        (q_full),
      .empty       (q_empty),
      .head        (head)
   );

   swt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!q_empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: dv/shell_word_tokenizer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// shell_word_tokenizer_tb
// Self-checking bench for the shell word tokenizer. A short table of
// directed bytes is walked first, then random command lines, each closed
// by an end-of-line beat. An in-bench tokenizer predicts every word byte,
// word end and line end, and each rsp beat is checked against the oldest
// prediction. Both stream sides idle and stall in random bursts.
// ---------------------------------------------------------------------------

module shell_word_tokenizer_tb;
   import swt_pkg::*;

   // one predicted result beat
   typedef struct packed {
      kind_type   kind;
      logic [7:0] ch;
      logic       last;
   } beat_type;

   // one directed stimulus row; typed rows carry their results by hand
   typedef struct packed {
      logic           act;
      logic [7:0]     ch;
      logic           typed;
      logic [1:0]     n;
      beat_type [0:2] beats;
   } row_type;

   localparam int RANDOM_ITEMS = 120;
   localparam int QUIET_AFTER  = 95;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] char_value
   logic       req_tuser = 1'b0;    // [0] action
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_char
   logic [1:0] rsp_tuser;           // [1:0] out_kind
   logic       rsp_tlast;

   // tokenizer state as predicted
   mode_type quote_mode;
   logic     esc_held;
   logic     word_open;
   beat_type step_out [0:2];
   int       step_cnt;

   beat_type word_beats_due [$];
   row_type  stim_rows [$];

   int  errors = 0;
   int  beats_checked = 0;
   int  items_sent = 0;
   int  lines_sent = 0;
   int  gap_pct = 0;
   bit  quiet = 1'b0;

   shell_word_tokenizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------
   function automatic beat_type bt(kind_type k, logic [7:0] c, logic l);
      beat_type b;
      b.kind = k;
      b.ch   = (k == KIND_BYTE) ? c : 8'h00;
      b.last = l;
      return b;
   endfunction

   function automatic void note(kind_type k, logic [7:0] c);
      if (step_cnt < 3) begin
         step_out[step_cnt] = bt(k, c, 1'b0);
         step_cnt++;
      end
   endfunction

   function automatic void word_byte(logic [7:0] c);
      note(KIND_BYTE, c);
      word_open = 1'b1;
   endfunction

   function automatic void end_word();
      if (word_open)
         note(KIND_WORD_END, 8'h00);
      word_open = 1'b0;
   endfunction

   function automatic bit is_blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic void tokenize_byte(logic act, logic [7:0] c);
      bit done;
      done = 1'b0;
      step_cnt = 0;
      if (act) begin
         if (esc_held)
            word_byte(CH_BSLASH);
         end_word();
         note(KIND_LINE_END, 8'h00);
         quote_mode = MODE_PLAIN;
         esc_held   = 1'b0;
         word_open  = 1'b0;
      end else if (quote_mode == MODE_SINGLE) begin
         word_open = 1'b1;
         if (c == CH_SQUOTE)
            quote_mode = MODE_PLAIN;
         else
            word_byte(c);
      end else if (quote_mode == MODE_DOUBLE) begin
         // a held backslash only escapes a few bytes, else it stays literal
         if (esc_held) begin
            esc_held = 1'b0;
            if (c == CH_DQUOTE || c == CH_BSLASH || c == CH_DOLLAR || c == CH_BTICK) begin
               word_byte(c);
               done = 1'b1;
            end else begin
               word_byte(CH_BSLASH);
            end
         end
         if (!done) begin
            word_open = 1'b1;
            if (c == CH_DQUOTE)
               quote_mode = MODE_PLAIN;
            else if (c == CH_BSLASH)
               esc_held = 1'b1;
            else
               word_byte(c);
         end
      end else begin
         // outside quotes
         if (esc_held) begin
            esc_held = 1'b0;
            word_byte(c);
         end else if (c == CH_PIPE) begin
            end_word();
            note(KIND_BYTE, CH_PIPE);
            note(KIND_WORD_END, 8'h00);
         end else if (is_blank(c)) begin
            end_word();
         end else if (c == CH_SQUOTE) begin
            quote_mode = MODE_SINGLE;
            word_open  = 1'b1;
         end else if (c == CH_DQUOTE) begin
            quote_mode = MODE_DOUBLE;
            word_open  = 1'b1;
         end else if (c == CH_BSLASH) begin
            esc_held = 1'b1;
         end else begin
            word_byte(c);
         end
      end
      if (step_cnt > 0)
         step_out[step_cnt-1].last = 1'b1;
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   task automatic send_item(input logic act, input logic [7:0] c, input row_type row);
      if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= c;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // beat accepted at this edge
      tokenize_byte(act, c);
      if (row.typed) begin
         for (int i = 0; i < row.n; i++)
            word_beats_due.insert(word_beats_due.size(), row.beats[i]);
      end else begin
         for (int i = 0; i < step_cnt; i++)
            word_beats_due.insert(word_beats_due.size(), step_out[i]);
      end
      items_sent++;
      if (act)
         lines_sent++;
   endtask

   task automatic add_row(input logic act, input logic [7:0] c, input logic typed,
                          input logic [1:0] n, input beat_type b0, input beat_type b1,
                          input beat_type b2);
      row_type r;
      r.act   = act;
      r.ch    = c;
      r.typed = typed;
      r.n     = n;
      r.beats = '{b0, b1, b2};
      stim_rows.insert(stim_rows.size(), r);
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 11))
         0:       return CH_SPACE;
         1:       return 8'($urandom_range(9, 13));
         2:       return CH_PIPE;
         3:       return CH_SQUOTE;
         4:       return CH_DQUOTE;
         5, 6:    return CH_BSLASH;
         7:       return CH_DOLLAR;
         8:       return CH_BTICK;
         9:       return 8'($urandom_range(8'h61, 8'h7A));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      row_type  plain_row;
      beat_type nb;
      int       len;
      nb = '0;
      plain_row = '0;
      quote_mode = MODE_PLAIN;
      esc_held   = 1'b0;
      word_open  = 1'b0;

      // directed table
      add_row(1'b1, 8'h00,     1'b1, 2'd1, bt(KIND_LINE_END, 8'h00, 1'b1), nb, nb);
      add_row(1'b0, 8'h00,     1'b1, 2'd1, bt(KIND_BYTE, 8'h00, 1'b1), nb, nb);
      add_row(1'b0, 8'hFF,     1'b1, 2'd1, bt(KIND_BYTE, 8'hFF, 1'b1), nb, nb);
      add_row(1'b0, CH_SPACE,  1'b1, 2'd1, bt(KIND_WORD_END, 8'h00, 1'b1), nb, nb);
      add_row(1'b0, CH_TAB,    1'b0, 2'd0, nb, nb, nb);   // blank, no word open
      add_row(1'b0, CH_PIPE,   1'b1, 2'd2, bt(KIND_BYTE, CH_PIPE, 1'b0),
              bt(KIND_WORD_END, 8'h00, 1'b1), nb);
      add_row(1'b0, 8'h78,     1'b1, 2'd1, bt(KIND_BYTE, 8'h78, 1'b1), nb, nb);
      add_row(1'b0, CH_PIPE,   1'b1, 2'd3, bt(KIND_WORD_END, 8'h00, 1'b0),
              bt(KIND_BYTE, CH_PIPE, 1'b0), bt(KIND_WORD_END, 8'h00, 1'b1));
      // escaped blank becomes a word byte, emitted when the blank arrives
      add_row(1'b0, CH_BSLASH, 1'b0, 2'd0, nb, nb, nb);
      add_row(1'b0, CH_SPACE,  1'b0, 2'd0, nb, nb, nb);
      // single quotes keep the backslash
      add_row(1'b0, CH_SQUOTE, 1'b0, 2'd0, nb, nb, nb);
      add_row(1'b0, CH_BSLASH, 1'b0, 2'd0, nb, nb, nb);
      add_row(1'b0, CH_SQUOTE, 1'b0, 2'd0, nb, nb, nb);
      add_row(1'b0, 8'h0B,     1'b0, 2'd0, nb, nb, nb);
      // empty quoted word still ends a word
      add_row(1'b0, CH_SQUOTE, 1'b0, 2'd0, nb, nb, nb);
      add_row(1'b0, CH_SQUOTE, 1'b0, 2'd0, nb, nb, nb);
      add_row(1'b0, 8'h0A,     1'b0, 2'd0, nb, nb, nb);
      // double quotes: kept backslash, escaped quote, held backslash at line end
      add_row(1'b0, CH_DQUOTE, 1'b0, 2'd0, nb, nb, nb);
      add_row(1'b0, CH_BSLASH, 1'b0, 2'd0, nb, nb, nb);
      add_row(1'b0, 8'h61,     1'b0, 2'd0, nb, nb, nb);
      add_row(1'b0, CH_BSLASH, 1'b0, 2'd0, nb, nb, nb);
      add_row(1'b0, CH_DQUOTE, 1'b0, 2'd0, nb, nb, nb);
      add_row(1'b0, CH_BSLASH, 1'b0, 2'd0, nb, nb, nb);
      add_row(1'b1, 8'h5A,     1'b1, 2'd3, bt(KIND_BYTE, CH_BSLASH, 1'b0),
              bt(KIND_WORD_END, 8'h00, 1'b0), bt(KIND_LINE_END, 8'h00, 1'b1));
      // unterminated single quote closed by line end
      add_row(1'b0, CH_SQUOTE, 1'b0, 2'd0, nb, nb, nb);
      add_row(1'b0, CH_PIPE,   1'b0, 2'd0, nb, nb, nb);
      add_row(1'b1, 8'hFF,     1'b0, 2'd0, nb, nb, nb);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         if (i % 6 == 0)
            gap_pct = $urandom_range(0, 3) * 15;
         send_item(stim_rows[i].act, stim_rows[i].ch, stim_rows[i]);
      end

      // random command lines, each closed by a line end
      while (items_sent < RANDOM_ITEMS + stim_rows.size()) begin
         gap_pct = $urandom_range(0, 3) * 15;
         quiet   = items_sent >= QUIET_AFTER + stim_rows.size();
         len     = $urandom_range(1, 14);
         for (int k = 0; k < len; k++)
            send_item(1'b0, pick_byte(), plain_row);
         send_item(1'b1, 8'($urandom_range(0, 255)), plain_row);
      end
      req_tvalid <= 1'b0;

      while (word_beats_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes in %0d lines; checked %0d result beats.",
               items_sent, lines_sent, beats_checked);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // response side: random stall bursts, none once quiet
   // ------------------------------------------------------------------
   initial begin
      int stall_pct;
      stall_pct = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 39) == 0)
            stall_pct = $urandom_range(0, 2) * 15;
         if (!quiet && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s at beat %0d: got %0h, expected %0h",
               what, beats_checked, got, want);
      errors++;
   endtask

   // result check
   always @(posedge clock) begin
      beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (word_beats_due.size() == 0) begin
            report_mismatch("unexpected beat, kind", rsp_tuser, 0);
         end else begin
            want = word_beats_due.pop_front();
            if (rsp_tuser !== want.kind)
               report_mismatch("out_kind", rsp_tuser, want.kind);
            if (rsp_tdata !== want.ch)
               report_mismatch("out_char", rsp_tdata, want.ch);
            if (rsp_tlast !== want.last)
               report_mismatch("last_of_run", rsp_tlast, want.last);
         end
         beats_checked++;
      end
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("Timeout with %0d result beats outstanding", word_beats_due.size());
      $display("Verification failed");
      $finish;
   end

endmodule
